/* rtl/ccp_pkg.sv */
// Shared types, codes and the microcode table of the ChaCha core permutation.
// Used by the sequencer, the datapath and the top level; depends on nothing.
package ccp_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_WORDS  = 16;
    localparam int IDX_W      = 4;
    localparam int NUM_LANES  = 4;
    localparam int UCODE_DEPTH = 8;
    localparam int PC_W       = 3;
    localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;
    localparam logic [3:0] DOUBLE_ROUNDS_RESET = 4'd10;

    // Rotate amounts of the four quarter-round steps.
    typedef enum logic [1:0] {
        ROT16 = 2'd0,
        ROT12 = 2'd1,
        ROT8  = 2'd2,
        ROT7  = 2'd3
    } ccp_rot_t;

    // Sequencer opcodes.
    typedef enum logic {
        OP_NEXT      = 1'b0,
        OP_ROUND_END = 1'b1
    } ccp_op_t;

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_RUN  = 3'b010,
        ST_EMIT = 3'b100
    } ccp_state_t;

    // One microcode word: which word group the lanes use, which half of the
    // quarter-round, the rotate, and the loop control.
    typedef struct packed {
        logic            diag;
        logic            sel_cd;
        ccp_rot_t        rot;
        ccp_op_t         op;
        logic [PC_W-1:0] target;
    } ccp_uword_t;

    // Control from sequencer to datapath.
    typedef struct packed {
        logic     load_shift;
        logic     emit_shift;
        logic     run;
        logic     diag;
        logic     sel_cd;
        ccp_rot_t rot;
    } ccp_ctrl_t;

    // One double round: column steps, then diagonal steps, then loop back.
    localparam ccp_uword_t UCODE [UCODE_DEPTH] = '{
        '{diag: 1'b0, sel_cd: 1'b0, rot: ROT16, op: OP_NEXT,      target: 3'd0},
        '{diag: 1'b0, sel_cd: 1'b1, rot: ROT12, op: OP_NEXT,      target: 3'd0},
        '{diag: 1'b0, sel_cd: 1'b0, rot: ROT8,  op: OP_NEXT,      target: 3'd0},
        '{diag: 1'b0, sel_cd: 1'b1, rot: ROT7,  op: OP_NEXT,      target: 3'd0},
        '{diag: 1'b1, sel_cd: 1'b0, rot: ROT16, op: OP_NEXT,      target: 3'd0},
        '{diag: 1'b1, sel_cd: 1'b1, rot: ROT12, op: OP_NEXT,      target: 3'd0},
        '{diag: 1'b1, sel_cd: 1'b0, rot: ROT8,  op: OP_NEXT,      target: 3'd0},
        '{diag: 1'b1, sel_cd: 1'b1, rot: ROT7,  op: OP_ROUND_END, target: 3'd0}
    };

endpackage

/* rtl/ccp_qstep.sv */
// One quarter-round step lane: add, xor, rotate.
// Depends on ccp_pkg for the rotate codes.
module ccp_qstep (
    input  logic [31:0]       x,
    input  logic [31:0]       y,
    input  logic [31:0]       z,
    input  ccp_pkg::ccp_rot_t rot,
    output logic [31:0]       x_new,
    output logic [31:0]       z_new
);
    import ccp_pkg::*;

    logic [31:0] mix;

    assign x_new = x + y;
    assign mix   = z ^ x_new;

    always_comb
    begin
        case (rot)
            ROT16:   z_new = {mix[15:0], mix[31:16]};
            ROT12:   z_new = {mix[19:0], mix[31:20]};
            ROT8:    z_new = {mix[23:0], mix[31:24]};
            ROT7:    z_new = {mix[24:0], mix[31:25]};
            default: z_new = mix;
        endcase
    end

endmodule

/* rtl/ccp_datapath.sv */
// State word registers with shift load/emit and four quarter-step lanes.
// Depends on ccp_pkg and ccp_qstep.
module ccp_datapath (
    input  logic               clk,
    input  ccp_pkg::ccp_ctrl_t ctrl,
    input  logic [31:0]        word_value,
    output logic [31:0]        result_word
);
    import ccp_pkg::*;

    logic [WORD_W-1:0] state_reg  [NUM_WORDS];
    logic [WORD_W-1:0] state_next [NUM_WORDS];
    logic [WORD_W-1:0] x_out [NUM_LANES];
    logic [WORD_W-1:0] z_out [NUM_LANES];

    genvar q, w;
    generate
        for (q = 0; q < NUM_LANES; q++)
        begin : g_lane
            localparam int IA  = q;
            localparam int IBC = 4 + q;
            localparam int ICC = 8 + q;
            localparam int IDC = 12 + q;
            localparam int IBD = 4 + (q + 1) % 4;
            localparam int ICD = 8 + (q + 2) % 4;
            localparam int IDD = 12 + (q + 3) % 4;

            logic [WORD_W-1:0] a, b, c, d, x, y, z;

            assign a = state_reg[IA];
            assign b = ctrl.diag ? state_reg[IBD] : state_reg[IBC];
            assign c = ctrl.diag ? state_reg[ICD] : state_reg[ICC];
            assign d = ctrl.diag ? state_reg[IDD] : state_reg[IDC];
            // First half: a += b, d ^= a. Second half: c += d, b ^= c.
            assign x = ctrl.sel_cd ? c : a;
            assign y = ctrl.sel_cd ? d : b;
            assign z = ctrl.sel_cd ? b : d;

            ccp_qstep u_qstep (
                .x     (x),
                .y     (y),
                .z     (z),
                .rot   (ctrl.rot),
                .x_new (x_out[q]),
                .z_new (z_out[q])
            );
        end

        for (w = 0; w < NUM_WORDS; w++)
        begin : g_word
            localparam int ROW  = w / 4;
            localparam int COL  = w % 4;
            localparam int LC   = COL;
            localparam int LD   = (COL - ROW + 4) % 4;

            logic [WORD_W-1:0] shift_in;
            logic [WORD_W-1:0] round_val;

            if (w == NUM_WORDS - 1)
            begin : g_tail
                assign shift_in = word_value;
            end
            else
            begin : g_body
                assign shift_in = state_reg[w + 1];
            end

            // Row 0 and 2 take the lane sum, rows 3 and 1 the rotated word.
            if (ROW == 0)
            begin : g_r0
                assign round_val = ctrl.sel_cd ? state_reg[w]
                                 : (ctrl.diag ? x_out[LD] : x_out[LC]);
            end
            else if (ROW == 2)
            begin : g_r2
                assign round_val = !ctrl.sel_cd ? state_reg[w]
                                 : (ctrl.diag ? x_out[LD] : x_out[LC]);
            end
            else if (ROW == 3)
            begin : g_r3
                assign round_val = ctrl.sel_cd ? state_reg[w]
                                 : (ctrl.diag ? z_out[LD] : z_out[LC]);
            end
            else
            begin : g_r1
                assign round_val = !ctrl.sel_cd ? state_reg[w]
                                 : (ctrl.diag ? z_out[LD] : z_out[LC]);
            end

            assign state_next[w] = (ctrl.load_shift || ctrl.emit_shift) ? shift_in
                                 : ctrl.run ? round_val
                                 : state_reg[w];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            state_reg[i] <= state_next[i];
        end
    end

    assign result_word = state_reg[0];

endmodule

/* rtl/ccp_sequencer.sv */
// Microcoded sequencer: load/run/emit control, step counter, round counter.
// Depends on ccp_pkg for the microcode table and control types.
module ccp_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               out_stall,
    input  logic [3:0]         double_rounds,
    output ccp_pkg::ccp_ctrl_t ctrl,
    output logic               in_stall,
    output logic               out_valid,
    output logic [3:0]         result_index,
    output logic               last_word
);
    import ccp_pkg::*;

    ccp_state_t      state_reg, state_next;
    logic [IDX_W-1:0] word_count_reg, word_count_next;
    logic [3:0]      round_count_reg, round_count_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ccp_uword_t      uword;
    logic            in_beat, out_beat;

    assign uword    = UCODE[pc_reg];
    assign in_stall  = (state_reg != ST_LOAD);
    assign out_valid = (state_reg == ST_EMIT);
    assign in_beat   = in_valid && !in_stall;
    assign out_beat  = out_valid && !out_stall;
    assign result_index = word_count_reg;
    assign last_word    = (word_count_reg == LAST_IDX);

    assign ctrl.load_shift = in_beat;
    assign ctrl.emit_shift = out_beat;
    assign ctrl.run        = (state_reg == ST_RUN);
    assign ctrl.diag       = uword.diag;
    assign ctrl.sel_cd     = uword.sel_cd;
    assign ctrl.rot        = uword.rot;

    always_comb
    begin
        state_next       = state_reg;
        word_count_next  = word_count_reg;
        round_count_next = round_count_reg;
        pc_next          = pc_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_beat)
                begin
                    word_count_next = word_count_reg + 4'd1;
                    if (word_count_reg == LAST_IDX)
                    begin
                        round_count_next = double_rounds;
                        pc_next          = '0;
                        state_next       = (double_rounds == 4'd0) ? ST_EMIT : ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                case (uword.op)
                    OP_ROUND_END:
                    begin
                        pc_next = uword.target;
                        if (round_count_reg == 4'd1)
                        begin
                            round_count_next = 4'd0;
                            state_next       = ST_EMIT;
                        end
                        else
                        begin
                            round_count_next = round_count_reg - 4'd1;
                        end
                    end
                    default:
                    begin
                        pc_next = pc_reg + 3'd1;
                    end
                endcase
            end
            ST_EMIT:
            begin
                if (out_beat)
                begin
                    word_count_next = word_count_reg + 4'd1;
                    if (word_count_reg == LAST_IDX)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            word_count_reg  <= '0;
            round_count_reg <= '0;
            pc_reg          <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            word_count_reg  <= word_count_next;
            round_count_reg <= round_count_next;
            pc_reg          <= pc_next;
        end
    end

endmodule

/* rtl/chacha_core_permutation_top.sv */
// Top level of the ChaCha core permutation: configuration register, sequencer
// and datapath. Depends on ccp_pkg, ccp_sequencer and ccp_datapath.
//
// The block takes the sixteen words of a ChaCha state, one beat each in index
// order, then runs the configured number of double rounds (no feed-forward
// add) and returns the sixteen permuted words in order with their index and a
// last marker on word 15. The round time is set by the microcode program:
// each of its eight steps runs one add-xor-rotate in four parallel lanes over
// the state registers. Input beats are held off while a block runs or is
// being emitted. The double_rounds register resets to 10; a write takes
// effect on the next block whose sixteenth word arrives after it. Zero rounds
// passes words through unchanged.
module chacha_core_permutation_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] word_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_word,
    output logic [3:0]  result_index,
    output logic        last_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);
    import ccp_pkg::*;

    logic [3:0] double_rounds_reg, double_rounds_next;
    ccp_ctrl_t  ctrl;

    // Always take config beats; the user must write only while idle, the block does not enforce it.
    assign cfg_ready = 1'b1;
    assign double_rounds_next = (cfg_valid && cfg_ready) ? cfg_data : double_rounds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            double_rounds_reg <= DOUBLE_ROUNDS_RESET;
        end
        else
        begin
            double_rounds_reg <= double_rounds_next;
        end
    end

    // Sequence load, rounds and emit from the microcode table.
    ccp_sequencer u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .out_stall     (out_stall),
        .double_rounds (double_rounds_reg),
        .ctrl          (ctrl),
        .in_stall      (in_stall),
        .out_valid     (out_valid),
        .result_index  (result_index),
        .last_word     (last_word)
    );

    // Hold the state words; shift them in and out, and mix them in rounds.
    ccp_datapath u_dp (
        .clk         (clk),
        .ctrl        (ctrl),
        .word_value  (word_value),
        .result_word (result_word)
    );

    // Never accept an input beat while results are on offer.
    a_no_load_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while emitting");

    // A block's results start at word 0.
    a_emit_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (result_index == 4'd0))
        else $error("emit did not start at word 0");

    // After the last word is taken the block returns to loading.
    a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_word) |=> (!out_valid && !in_stall))
        else $error("emit did not end after last word");

    // Rounds never run while loading or emitting.
    a_run_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.run |-> (in_stall && !out_valid))
        else $error("rounds overlap load or emit");

endmodule

/* tb/sv/tb_chacha_core_permutation_top.sv */
// Self-checking bench for chacha_core_permutation_top: loads 16-word states,
// predicts the permuted words in place and checks every result beat.
// Depends on ccp_pkg and the RTL of chacha_core_permutation_top.
module tb_chacha_core_permutation_top;

    import ccp_pkg::*;

    // Receiver hold-off used to fill the block, and the quiet-cycle limit.
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 4000;
    // Settle time before a register write, and the tail at the end of the run:
    // one full block at the largest round count and margin.
    localparam int SETTLE_CYCLES   = 20;
    localparam int TAIL_CYCLES     = 160;
    localparam int NUM_PHASES      = 7;
    localparam int BLOCKS_PER_PHASE = 4;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  index;
        logic              last;
    } chacha_result_t;

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [31:0]       word_value   = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [31:0]       result_word;
    logic [3:0]        result_index;
    logic              last_word;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [3:0]        cfg_data     = '0;

    // Words waiting to be offered, and permuted words waiting to come out.
    logic [WORD_W-1:0] words_pending[$];
    chacha_result_t    expected_results[$];

    // Predictor copy of the state array, load position and round count.
    logic [WORD_W-1:0] chacha_words [NUM_WORDS];
    logic [IDX_W-1:0]  load_pos       = '0;
    logic [3:0]        rounds_setting = DOUBLE_ROUNDS_RESET;

    // Idling percentages per phase, and the hold-off handshake between the
    // stimulus process and the receiver.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_asked = 0;
    int hold_off_taken = 0;
    int hold_off_left  = 0;
    int error_count    = 0;

    chacha_core_permutation_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .word_value   (word_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_word  (result_word),
        .result_index (result_index),
        .last_word    (last_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: one ChaCha double round is four column quarter-rounds and
    // four diagonal quarter-rounds over the 16-word state, no feed-forward.
    // ------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] rotl32(logic [WORD_W-1:0] x, int amount);
        return (x << amount) | (x >> (WORD_W - amount));
    endfunction

    task automatic quarter_round(input int a, input int b, input int c, input int d);
        chacha_words[a] = chacha_words[a] + chacha_words[b];
        chacha_words[d] = rotl32(chacha_words[d] ^ chacha_words[a], 16);
        chacha_words[c] = chacha_words[c] + chacha_words[d];
        chacha_words[b] = rotl32(chacha_words[b] ^ chacha_words[c], 12);
        chacha_words[a] = chacha_words[a] + chacha_words[b];
        chacha_words[d] = rotl32(chacha_words[d] ^ chacha_words[a], 8);
        chacha_words[c] = chacha_words[c] + chacha_words[d];
        chacha_words[b] = rotl32(chacha_words[b] ^ chacha_words[c], 7);
    endtask

    // Permute the loaded state with the current setting and queue the
    // sixteen words it must return, last marker on word 15.
    task automatic permute_and_queue();
        chacha_result_t r;
        for (int n = 0; n < rounds_setting; n++)
        begin
            quarter_round(0, 4, 8, 12);
            quarter_round(1, 5, 9, 13);
            quarter_round(2, 6, 10, 14);
            quarter_round(3, 7, 11, 15);
            quarter_round(0, 5, 10, 15);
            quarter_round(1, 6, 11, 12);
            quarter_round(2, 7, 8, 13);
            quarter_round(3, 4, 9, 14);
        end
        for (int k = 0; k < NUM_WORDS; k++)
        begin
            r.word  = chacha_words[k];
            r.index = IDX_W'(k);
            r.last  = (IDX_W'(k) == LAST_IDX);
            expected_results.push_back(r);
        end
    endtask

    function automatic bit field_differs(string field, logic [31:0] want, logic [31:0] got);
        if (want === got)
            return 1'b0;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer the next pending word, hold it while stalled, and idle
    // at random only between beats so a stalled payload never changes.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            word_value <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (words_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid   <= 1'b1;
                word_value <= words_pending.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall at random, or for a long stretch when asked, so the
    // block backs up and stalls its own input.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall      <= 1'b0;
            hold_off_left  <= 0;
            hold_off_taken <= 0;
        end
        else if (hold_off_taken != hold_off_asked)
        begin
            hold_off_taken <= hold_off_asked;
            hold_off_left  <= HOLD_OFF_CYCLES;
            out_stall      <= 1'b1;
        end
        else if (hold_off_left != 0)
        begin
            hold_off_left <= hold_off_left - 1;
            out_stall     <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result beat against the oldest expectation, then
    // feed accepted input beats and register writes into the predictor.
    // Values are sampled before this edge's updates land.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        chacha_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual word %h index %0d last %b",
                             $time, result_word, result_index, last_word);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (field_differs("result_word", want.word, result_word)
                        | field_differs("result_index", 32'(want.index), 32'(result_index))
                        | field_differs("last_word", 32'(want.last), 32'(last_word)))
                        error_count++;
                end
            end
            if (cfg_valid && cfg_ready)
                rounds_setting = cfg_data;
            if (in_valid && !in_stall)
            begin
                chacha_words[load_pos] = word_value;
                if (load_pos == LAST_IDX)
                    permute_and_queue();
                load_pos = load_pos + 1'b1;
            end
        end
    end

    // Watchdog: end the run after too many cycles with no beat anywhere.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Write double_rounds; the write lands at the edge with valid and ready.
    task automatic write_double_rounds(input logic [3:0] setting);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= setting;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Pause the sender until every word is out and every result is back,
    // then let the block settle before anything else is touched.
    task automatic drain();
        while (words_pending.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        @(negedge clk);
        case (mode)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [WORD_W-1:0] edge_words [NUM_WORDS];
        logic [3:0]        phase_rounds [NUM_PHASES];

        // Extremes of the word, single set bits, alternating patterns and
        // the ChaCha constant words.
        edge_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                       32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'hFFFF_FFFE,
                       32'h6170_7865, 32'h3320_646E, 32'h7962_2D32, 32'h6B20_6574,
                       32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'h9ABC_DEF0};
        // Cover both ends of the register, the common ChaCha variants and
        // one value picked by the seed.
        phase_rounds = '{4'd15, 4'd10, 4'd0, 4'd6, 4'd4, 4'd1, 4'd15};
        phase_rounds[5] = 4'($urandom_range(15));

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed block: load half the state under the reset setting, then
        // switch to zero rounds mid-block. The setting held at word 15 wins,
        // so the words must come back unchanged.
        @(negedge clk);
        for (int k = 0; k < NUM_WORDS / 2; k++)
            words_pending.push_back(edge_words[k]);
        drain();
        write_double_rounds(4'd0);
        @(negedge clk);
        for (int k = NUM_WORDS / 2; k < NUM_WORDS; k++)
            words_pending.push_back(edge_words[k]);
        drain();

        // Random phases: new setting each phase, rotating through the idling
        // modes. Every block is a full 16-word state with random content.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_double_rounds(phase_rounds[p]);
            set_idling(p % 4);
            // Hold the receiver off while the sender keeps offering, so the
            // block fills and stalls its input.
            if (p == 4)
                hold_off_asked = hold_off_asked + 1;
            for (int b = 0; b < BLOCKS_PER_PHASE * NUM_WORDS; b++)
                words_pending.push_back($urandom);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
